FILE: design/rep_pkg.sv
// shared types and constants for the range equal-pair probability block
package rep_pkg;

  localparam int unsigned SeqDepth   = 4096;
  localparam int unsigned ColorCount = 4096;
  localparam int unsigned PosW       = 13;
  localparam int unsigned AddrW      = 12;
  localparam int unsigned ColW       = 12;
  localparam int unsigned CntW       = 13;
  localparam int unsigned SumW       = 25;
  localparam int unsigned ValW       = 24;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic            action;
    logic [PosW-1:0] position;
    logic [ColW-1:0] color_value;
    logic [PosW-1:0] range_left;
    logic [PosW-1:0] range_right;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] numerator;
    logic [ValW-1:0] denominator;
    logic            status;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_CRD,
    ST_LD_CWR,
    ST_LD_WR,
    ST_LD_CRD2,
    ST_LD_CWR2,
    ST_WALK,
    ST_SL_RD,
    ST_SL_CRD,
    ST_SL_CWR,
    ST_DEN,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_t;

endpackage

FILE: design/range_equal_pair_probability.sv
// top level: sequence store, window walk, count update and reduced fraction
//
//  channel | direction | payload      | handshake
//  in      | input     | in_item_t    | in_valid / in_stall
//  out     | output    | out_item_t   | out_valid / out_stall
//
// a load ends early (bad position), writes the store (outside the window) or also
// updates the counts (inside it); a query does, per window step, a walk decision,
// memory read, count read and count write, then forms len*(len-1), runs the euclid
// steps, hands over the gcd and does two divisions, all on one shared divider
// after reset a clearing pass zeroes the count memory; the
// sequence memory is cleared in the same pass
// the input is stalled whenever an item is at work; a stalled result holds
module range_equal_pair_probability (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rep_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rep_pkg::out_item_t  out_data
);
  import rep_pkg::*;

  // memories
  logic [ColW-1:0] color_store [SeqDepth];
  logic [CntW-1:0] color_counts [ColorCount];
  logic [ColW-1:0] store_rd;
  logic [CntW-1:0] count_rd;

  state_t state, state_next;

  in_item_t        item;
  logic [AddrW:0]  clr_idx;
  logic [PosW-1:0] win_l, win_r, lo, hi;
  logic [SumW-1:0] square_sum;
  logic [PosW-1:0] slide_pos;
  logic            slide_grow;
  logic [ColW-1:0] slide_col;
  logic            ld_phase;

  // shared divider: a / b bit-serial, also gives remainder
  logic [SumW-1:0] dv_a, dv_b, dv_r;
  logic [4:0]      dv_cnt;
  logic [SumW-1:0] g_a, g_b, num, den;
  logic [SumW:0]   rem_sh;
  logic            dv_ge;
  logic [SumW-1:0] dv_rem;
  logic [SumW-1:0] den_sq;

  logic [PosW-1:0] len;
  logic            in_win;

  always_comb begin
    lo  = (item.range_left == '0) ? PosW'(1) : item.range_left;
    hi  = (item.range_right > PosW'(SeqDepth)) ? PosW'(SeqDepth) : item.range_right;
    len = hi - lo + PosW'(1);
    in_win = (item.position >= win_l) && (item.position <= win_r);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_idx == (AddrW+1)'(SeqDepth - 1)) state_next = ST_IDLE;
      ST_IDLE:    if (in_valid) state_next = (in_data.action == ActLoad) ? ST_LD_RD : ST_WALK;
      ST_LD_RD:   state_next = (item.position == '0 ||
                                item.position > PosW'(SeqDepth)) ? ST_IDLE :
                               (in_win ? ST_LD_CRD : ST_LD_WR);
      ST_LD_CRD:  state_next = ST_LD_CWR;
      ST_LD_CWR:  state_next = ST_LD_WR;
      ST_LD_WR:   state_next = ld_phase ? ST_LD_CRD2 : ST_IDLE;
      ST_LD_CRD2: state_next = ST_LD_CWR2;
      ST_LD_CWR2: state_next = ST_IDLE;
      ST_WALK: begin
        if (lo > hi) state_next = ST_OUT;
        else if (win_r < hi || win_l > lo || win_r > hi || win_l < lo)
          state_next = ST_SL_RD;
        else if (len == PosW'(1)) state_next = ST_OUT;
        else state_next = ST_DEN;
      end
      ST_SL_RD:   state_next = ST_SL_CRD;
      ST_SL_CRD:  state_next = ST_SL_CWR;
      ST_SL_CWR:  state_next = ST_WALK;
      ST_DEN:     state_next = ST_GCD;
      ST_GCD:     if (g_b == '0) state_next = ST_DIVN;
      ST_DIVN:    if (dv_cnt == 5'd0 && g_b != '0) state_next = ST_DIVD;
      ST_DIVD:    if (dv_cnt == 5'd0 && g_b != '0) state_next = ST_OUT;
      ST_OUT:     if (!out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      color_store[clr_idx[AddrW-1:0]]  <= '0;
      color_counts[clr_idx[AddrW-1:0]] <= '0;
    end else begin
      if (state == ST_LD_WR) color_store[AddrW'(item.position - PosW'(1))] <= item.color_value;
      if (state == ST_SL_CWR || state == ST_LD_CWR || state == ST_LD_CWR2)
        color_counts[slide_col] <= slide_grow ? count_rd + CntW'(1) :
                                   (count_rd != '0 ? count_rd - CntW'(1) : count_rd);
    end
    store_rd <= color_store[AddrW'(slide_pos - PosW'(1))];
    count_rd <= color_counts[(state == ST_LD_WR) ? item.color_value :
                             ((state == ST_SL_CRD || state == ST_LD_CRD) ? store_rd
                                                                         : slide_col)];
  end

  // divider step: restoring, one quotient bit per cycle
  always_comb begin
    rem_sh = {dv_r, dv_a[SumW-1]};
    dv_ge  = (rem_sh >= {1'b0, dv_b});
    dv_rem = dv_ge ? SumW'(rem_sh - {1'b0, dv_b}) : rem_sh[SumW-1:0];
    den_sq = SumW'(den[PosW-1:0]) * SumW'(den[PosW-1:0] - PosW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      win_l   <= PosW'(1);
      win_r   <= '0;
      square_sum <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + (AddrW+1)'(1);
      unique case (state)
        ST_IDLE: if (in_valid) begin
          item      <= in_data;
          slide_pos <= in_data.position;
          ld_phase  <= 1'b0;
        end
        ST_LD_RD: begin
          slide_grow <= 1'b0;
          ld_phase   <= in_win;
        end
        ST_LD_CRD: slide_col <= store_rd;
        ST_LD_CWR, ST_LD_CWR2, ST_SL_CWR: begin
          if (slide_grow)
            square_sum <= square_sum + SumW'({count_rd, 1'b1});
          else if (count_rd != '0)
            square_sum <= square_sum - SumW'({count_rd, 1'b0}) + SumW'(1);
        end
        ST_LD_WR: begin
          slide_col  <= item.color_value;
          slide_grow <= 1'b1;
        end
        ST_WALK: begin
          if (!(lo > hi)) begin
            if (win_r < hi) begin
              win_r <= win_r + PosW'(1); slide_pos <= win_r + PosW'(1);
              slide_grow <= 1'b1;
            end else if (win_l > lo) begin
              win_l <= win_l - PosW'(1); slide_pos <= win_l - PosW'(1);
              slide_grow <= 1'b1;
            end else if (win_r > hi) begin
              win_r <= win_r - PosW'(1); slide_pos <= win_r;
              slide_grow <= 1'b0;
            end else if (win_l < lo) begin
              win_l <= win_l + PosW'(1); slide_pos <= win_l;
              slide_grow <= 1'b0;
            end
          end
          num <= square_sum - SumW'(len);
          den <= SumW'(len);
        end
        ST_SL_CRD: slide_col <= store_rd;
        ST_DEN: begin
          den  <= den_sq;
          g_a  <= num;
          g_b  <= den_sq;
          dv_a <= num; dv_b <= den_sq; dv_r <= '0; dv_cnt <= 5'(SumW - 1);
        end
        ST_GCD, ST_DIVN, ST_DIVD: begin
          if (g_b == '0) begin
            // gcd settled in g_a: start next division
            dv_b <= g_a; dv_r <= '0; dv_cnt <= 5'(SumW - 1);
            g_b  <= g_a;
            dv_a <= (state == ST_GCD) ? num : den;
          end else if (dv_cnt != 5'd0) begin
            dv_a   <= {dv_a[SumW-2:0], dv_ge};
            dv_r   <= dv_rem;
            dv_cnt <= dv_cnt - 5'd1;
          end else begin
            // last quotient bit of this pass
            dv_cnt <= 5'(SumW - 1);
            dv_r   <= '0;
            if (state == ST_GCD) begin
              g_a  <= g_b;
              g_b  <= dv_rem;
              dv_a <= g_b;
              dv_b <= dv_rem;
            end else if (state == ST_DIVN) begin
              num  <= {dv_a[SumW-2:0], dv_ge};
              dv_a <= den;
            end else begin
              den <= {dv_a[SumW-2:0], dv_ge};
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lo > hi) begin
      out_data = '{numerator: ValW'(0), denominator: ValW'(1), status: 1'b1};
    end else if (len == PosW'(1)) begin
      out_data = '{numerator: ValW'(0), denominator: ValW'(1), status: 1'b0};
    end else begin
      out_data = '{numerator: num[ValW-1:0], denominator: den[ValW-1:0], status: 1'b0};
    end
  end

endmodule

FILE: design/rep_checker.sv
// port-level checks for the range equal-pair probability block
module rep_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rep_pkg::out_item_t out_data
);
  import rep_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no input taken while a result is shown
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // an accepted transfer leaves the block busy in the cycle after it
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // an invalid range always gives zero over one
  a_bad_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.numerator == '0 &&
    out_data.denominator == ValW'(1))
    else $error("flagged result not 0/1");

  // denominator never zero
  a_den_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.denominator != '0)
    else $error("zero denominator");

endmodule

bind range_equal_pair_probability rep_checker u_rep_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
